[src/edf_pkg.sv]
// edf_pkg: shared types and codes for the EDF tick scheduler.
// Holds the task table entry layout, run state codes, event kinds and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package edf_pkg;

    // run state codes
    localparam logic [2:0] RS_UNREL   = 3'd0;
    localparam logic [2:0] RS_REL     = 3'd1;
    localparam logic [2:0] RS_RUN     = 3'd2;
    localparam logic [2:0] RS_PREEMPT = 3'd3;
    localparam logic [2:0] RS_MISSED  = 3'd4;
    localparam logic [2:0] RS_DONE    = 3'd5;

    // event kinds
    localparam logic [2:0] EV_DONE    = 3'd0;
    localparam logic [2:0] EV_MISS    = 3'd1;
    localparam logic [2:0] EV_PREEMPT = 3'd2;
    localparam logic [2:0] EV_RESUME  = 3'd3;
    localparam logic [2:0] EV_TICK    = 3'd4;

    // configuration register indexes
    localparam logic [0:0] REG_TASK_COUNT = 1'd0;
    localparam logic [0:0] REG_APER_DL    = 1'd1;

    localparam logic [3:0]  TASK_COUNT_RST = 4'd1;
    localparam logic [15:0] APER_DL_RST    = 16'd500;

    localparam logic signed [17:0] CD_MIN  = -18'sd131072;
    localparam logic signed [17:0] CD_NEG1 = -18'sd1;

    // one task table entry
    typedef struct packed {
        logic               ap;   // aperiodic flag
        logic [15:0]        per;  // reload period / release delay
        logic [15:0]        ex;   // reload execution time
        logic signed [17:0] cd;   // deadline countdown
        logic [15:0]        rem;  // remaining execution
        logic [2:0]         st;   // run state
    } t_entry;

endpackage

[src/edf_tick_scheduler.sv]
// edf_tick_scheduler: earliest-deadline-first tick scheduler, top level.
// Load beat: table write, then bubble re-sort passes until a pass makes no swap.
// Tick beat: mark / reload walk over used slots, re-sort if reloaded, preemption walk, then
//   pick walk (stops at the runner), countdown decrement over used ids and tick end beat,
//   plus event beats and output stalls; one beat at a time, the single-port task memory sets the pace.
// Synchronous active-low reset clears counters, order and entry valid bits; no clearing sweep.
`timescale 1ns / 1ps

module edf_tick_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // task_id[2:0], is_aperiodic[3], task_deadline[19:4],
                                       // exec_time[35:20], zero pad
    input  logic [0:0]  s_axis_tuser,  // action[0]
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // event_task[2:0], any_running[3], tick_time[35:4],
                                       // preempt_total[51:36], miss_total[67:52], zero pad
    output logic [2:0]  m_axis_tuser,  // event_kind[2:0]
    output logic        m_axis_tlast,  // last_event
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IDXW = $clog2(MAX_TASKS);
    localparam int PW   = IDXW + 1;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_W_RD = 16'h0002,  // mark / reload walk in priority order
        S_W_EX = 16'h0004,
        S_W_EM = 16'h0008,
        S_SPRE = 16'h0010,  // bubble sort pass setup
        S_SLD  = 16'h0020,
        S_SCMP = 16'h0040,
        S_P_RD = 16'h0080,  // preemption walk
        S_P_EX = 16'h0100,
        S_P_EM = 16'h0200,
        S_R_RD = 16'h0400,  // pick runner
        S_R_EX = 16'h0800,
        S_R_EM = 16'h1000,
        S_D_RD = 16'h2000,  // countdown decrement by id
        S_D_EX = 16'h4000,
        S_T_EM = 16'h8000   // tick end beat
    } t_state;

    t_state               r_state;
    logic [PW-1:0]        r_pos;
    logic [IDXW-1:0]      r_t;
    edf_pkg::t_entry      r_ent;
    logic                 r_ec, r_em, r_reload, r_seen, r_ran, r_from_load, r_swapped;
    logic [IDXW-1:0]      r_runner;
    logic signed [17:0]   r_carry_cd;
    logic [15:0]          r_carry_rem;
    logic [IDXW-1:0]      r_order [MAX_TASKS];
    logic [3:0]           r_task_count;
    logic [15:0]          r_apd;
    logic [31:0]          r_time;
    logic [15:0]          r_pcnt, r_mcnt;

    // task table memory, one read port with registered data, one write port
    edf_pkg::t_entry      r_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;
    edf_pkg::t_entry      r_rd;
    logic                 r_rd_vld;

    // output register
    logic                 r_ovalid, r_orun, r_olast;
    logic [2:0]           r_okind, r_otask;
    logic [31:0]          r_otime;
    logic [15:0]          r_opc, r_omc;

    logic [PW-1:0]        n_eff;
    logic [IDXW-1:0]      cur_t, rd_addr, w_addr;
    logic                 pos_end, in_use, slot_free;
    edf_pkg::t_entry      rd_ent, w_ent, w_data, run_ent;
    logic                 w_ec, w_em, w_rl, w_we;
    logic [PW-1:0]        idx2;
    logic signed [33:0]   ap_diff;
    logic signed [17:0]   ap_cd;
    logic                 swap_now, st_active;
    logic                 e_go, e_run, e_last, e_pinc, e_minc;
    logic [2:0]           e_kind;
    logic [IDXW-1:0]      e_task;
    logic [15:0]          n_pcnt, n_mcnt;
    logic [2:0]           in_id;
    logic                 load_ok;

    function automatic logic goes_after(input logic signed [17:0] a_cd, input logic [15:0] a_rem,
                                        input logic signed [17:0] b_cd, input logic [15:0] b_rem);
        if (a_cd != b_cd) begin
            return a_cd > b_cd;
        end
        return a_rem > b_rem;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign slot_free     = !r_ovalid || m_axis_tready;
    assign in_id         = s_axis_tdata[2:0];
    assign load_ok       = (int'(in_id) < MAX_TASKS);

    always_comb begin
        if (int'(r_task_count) > MAX_TASKS) begin
            n_eff = PW'(MAX_TASKS);
        end else begin
            n_eff = PW'(r_task_count);
        end
    end

    assign pos_end = (r_pos == PW'(MAX_TASKS));
    assign cur_t   = r_order[r_pos[IDXW-1:0]];
    assign in_use  = ({1'b0, cur_t} < n_eff);
    assign idx2    = r_pos + PW'(2);
    assign rd_ent  = r_rd_vld ? r_rd : '0;

    // read address per phase
    always_comb begin
        rd_addr = '0;
        case (r_state)
            S_W_RD, S_P_RD, S_R_RD: rd_addr = cur_t;
            S_D_RD:                 rd_addr = r_pos[IDXW-1:0];
            S_SPRE:                 rd_addr = r_order[0];
            S_SLD:                  rd_addr = r_order[1];
            S_SCMP: begin
                if (idx2 < PW'(MAX_TASKS)) begin
                    rd_addr = r_order[idx2[IDXW-1:0]];
                end
            end
            default:                rd_addr = '0;
        endcase
    end

    // mark / reload of one entry
    assign ap_diff = $signed({18'd0, r_apd}) - $signed({2'd0, r_time});
    assign ap_cd   = (ap_diff < -34'sd131072) ? edf_pkg::CD_MIN : ap_diff[17:0];

    always_comb begin
        w_ent = rd_ent;
        w_ec  = 1'b0;
        w_em  = 1'b0;
        w_rl  = 1'b0;
        // first tick releases periodic tasks
        if (r_time == 32'd0 && !w_ent.ap) begin
            w_ent.st = edf_pkg::RS_REL;
        end
        if (w_ent.rem == 16'd0 && w_ent.st != edf_pkg::RS_DONE) begin
            w_ent.st = edf_pkg::RS_DONE;
            w_ec     = 1'b1;
        end
        if (w_ent.cd == 18'sd0) begin
            if (w_ent.rem != 16'd0 && w_ent.st != edf_pkg::RS_UNREL) begin
                w_ent.st = edf_pkg::RS_MISSED;
                w_em     = 1'b1;
            end
            w_rl = 1'b1;
            if (w_ent.ap) begin
                if (w_ent.st != edf_pkg::RS_DONE) begin
                    w_ent.cd = ap_cd;
                    w_ent.st = edf_pkg::RS_REL;
                end else begin
                    w_ent.cd = edf_pkg::CD_NEG1;
                end
            end else begin
                w_ent.cd  = $signed({2'b00, w_ent.per});
                w_ent.rem = w_ent.ex;
                w_ent.st  = edf_pkg::RS_REL;
            end
        end
    end

    assign swap_now  = goes_after(r_carry_cd, r_carry_rem, rd_ent.cd, rd_ent.rem);
    assign st_active = (rd_ent.st == edf_pkg::RS_REL) || (rd_ent.st == edf_pkg::RS_RUN)
                       || (rd_ent.st == edf_pkg::RS_PREEMPT);

    always_comb begin
        run_ent     = rd_ent;
        run_ent.st  = edf_pkg::RS_RUN;
        if (rd_ent.rem != 16'd0) begin
            run_ent.rem = rd_ent.rem - 16'd1;
        end
    end

    // memory write port
    always_comb begin
        w_we   = 1'b0;
        w_addr = '0;
        w_data = r_ent;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && !s_axis_tuser[0] && load_ok) begin
                    w_we       = 1'b1;
                    w_addr     = IDXW'(in_id);
                    w_data.ap  = s_axis_tdata[3];
                    w_data.per = s_axis_tdata[19:4];
                    w_data.ex  = s_axis_tdata[35:20];
                    w_data.cd  = $signed({2'b00, s_axis_tdata[19:4]});
                    w_data.rem = s_axis_tdata[35:20];
                    w_data.st  = edf_pkg::RS_UNREL;
                end
            end
            S_W_EM: begin
                if (!r_ec && !r_em) begin
                    w_we   = 1'b1;
                    w_addr = r_t;
                end
            end
            S_P_EM, S_R_EM: begin
                if (slot_free) begin
                    w_we   = 1'b1;
                    w_addr = r_t;
                end
            end
            S_R_EX: begin
                if (st_active && rd_ent.st != edf_pkg::RS_PREEMPT) begin
                    w_we   = 1'b1;
                    w_addr = r_t;
                    w_data = run_ent;
                end
            end
            S_D_EX: begin
                if (rd_ent.cd >= 18'sd0) begin
                    w_we      = 1'b1;
                    w_addr    = r_t;
                    w_data    = rd_ent;
                    w_data.cd = rd_ent.cd - 18'sd1;
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    // event beats
    always_comb begin
        e_go   = 1'b0;
        e_kind = edf_pkg::EV_TICK;
        e_task = r_t;
        e_run  = 1'b0;
        e_last = 1'b0;
        e_pinc = 1'b0;
        e_minc = 1'b0;
        case (r_state)
            S_W_EM: begin
                if (slot_free && r_ec) begin
                    e_go   = 1'b1;
                    e_kind = edf_pkg::EV_DONE;
                end else if (slot_free && r_em) begin
                    e_go   = 1'b1;
                    e_kind = edf_pkg::EV_MISS;
                    e_minc = 1'b1;
                end
            end
            S_P_EM: begin
                e_go   = slot_free;
                e_kind = edf_pkg::EV_PREEMPT;
                e_pinc = slot_free;
            end
            S_R_EM: begin
                e_go   = slot_free;
                e_kind = edf_pkg::EV_RESUME;
            end
            S_T_EM: begin
                e_go   = slot_free;
                e_kind = edf_pkg::EV_TICK;
                e_task = r_runner;
                e_run  = r_ran;
                e_last = 1'b1;
            end
            default: e_go = 1'b0;
        endcase
    end

    assign n_pcnt = (e_pinc && r_pcnt != 16'hFFFF) ? r_pcnt + 16'd1 : r_pcnt;
    assign n_mcnt = (e_minc && r_mcnt != 16'hFFFF) ? r_mcnt + 16'd1 : r_mcnt;

    // task memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd     <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (e_go) begin
            r_okind <= e_kind;
            r_otask <= 3'(e_task);
            r_orun  <= e_run;
            r_otime <= r_time;
            r_opc   <= n_pcnt;
            r_omc   <= n_mcnt;
            r_olast <= e_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_vld        <= '0;
            r_task_count <= edf_pkg::TASK_COUNT_RST;
            r_apd        <= edf_pkg::APER_DL_RST;
            r_time       <= '0;
            r_pcnt       <= '0;
            r_mcnt       <= '0;
            r_pos        <= '0;
            r_ec         <= 1'b0;
            r_em         <= 1'b0;
            r_reload     <= 1'b0;
            r_seen       <= 1'b0;
            r_ran        <= 1'b0;
            r_runner     <= '0;
            r_from_load  <= 1'b0;
            r_swapped    <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_order[i] <= IDXW'(i);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    edf_pkg::REG_TASK_COUNT: r_task_count <= i_cfg_wdata[3:0];
                    edf_pkg::REG_APER_DL:    r_apd        <= i_cfg_wdata;
                    default:                 r_apd        <= r_apd;
                endcase
            end
            if (e_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_pcnt <= n_pcnt;
            r_mcnt <= n_mcnt;
            if (w_we) begin
                r_vld[w_addr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pos <= '0;
                        if (s_axis_tuser[0]) begin
                            r_reload <= 1'b0;
                            r_ran    <= 1'b0;
                            r_runner <= '0;
                            r_state  <= S_W_RD;
                        end else if (load_ok) begin
                            r_from_load <= 1'b1;
                            r_state     <= S_SPRE;
                        end
                    end
                end
                S_W_RD: begin
                    if (pos_end) begin
                        r_pos <= '0;
                        if (r_reload) begin
                            r_from_load <= 1'b0;
                            r_state     <= S_SPRE;
                        end else begin
                            r_seen  <= 1'b0;
                            r_state <= S_P_RD;
                        end
                    end else if (!in_use) begin
                        r_pos <= r_pos + PW'(1);
                    end else begin
                        r_t     <= cur_t;
                        r_state <= S_W_EX;
                    end
                end
                S_W_EX: begin
                    r_ent    <= w_ent;
                    r_ec     <= w_ec;
                    r_em     <= w_em;
                    r_reload <= r_reload | w_rl;
                    r_state  <= S_W_EM;
                end
                S_W_EM: begin
                    if (r_ec) begin
                        if (slot_free) r_ec <= 1'b0;
                    end else if (r_em) begin
                        if (slot_free) r_em <= 1'b0;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_W_RD;
                    end
                end
                S_SPRE: begin
                    r_pos     <= '0;
                    r_swapped <= 1'b0;
                    r_state   <= S_SLD;
                end
                S_SLD: begin
                    r_carry_cd  <= rd_ent.cd;
                    r_carry_rem <= rd_ent.rem;
                    r_state     <= S_SCMP;
                end
                S_SCMP: begin
                    // carried entry is the larger of the pair and moves on
                    if (swap_now) begin
                        r_order[r_pos[IDXW-1:0]]            <= r_order[idx2[IDXW-1:0] - IDXW'(1)];
                        r_order[idx2[IDXW-1:0] - IDXW'(1)]  <= r_order[r_pos[IDXW-1:0]];
                        r_swapped                           <= 1'b1;
                    end else begin
                        r_carry_cd  <= rd_ent.cd;
                        r_carry_rem <= rd_ent.rem;
                    end
                    if (r_pos == PW'(MAX_TASKS - 2)) begin
                        r_pos <= '0;
                        if (r_swapped || swap_now) begin
                            r_state <= S_SPRE;
                        end else if (r_from_load) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_seen  <= 1'b0;
                            r_state <= S_P_RD;
                        end
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                S_P_RD: begin
                    if (pos_end) begin
                        r_pos   <= '0;
                        r_state <= S_R_RD;
                    end else if (!in_use) begin
                        r_pos <= r_pos + PW'(1);
                    end else begin
                        r_t     <= cur_t;
                        r_state <= S_P_EX;
                    end
                end
                S_P_EX: begin
                    if (rd_ent.st == edf_pkg::RS_RUN && r_seen) begin
                        r_ent   <= edf_pkg::t_entry'({rd_ent.ap, rd_ent.per, rd_ent.ex,
                                                      rd_ent.cd, rd_ent.rem,
                                                      edf_pkg::RS_PREEMPT});
                        r_state <= S_P_EM;
                    end else begin
                        if (rd_ent.st == edf_pkg::RS_RUN) r_seen <= 1'b1;
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_P_RD;
                    end
                end
                S_P_EM: begin
                    if (slot_free) begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_P_RD;
                    end
                end
                S_R_RD: begin
                    if (pos_end) begin
                        r_pos   <= '0;
                        r_state <= S_D_RD;
                    end else if (!in_use) begin
                        r_pos <= r_pos + PW'(1);
                    end else begin
                        r_t     <= cur_t;
                        r_state <= S_R_EX;
                    end
                end
                S_R_EX: begin
                    if (st_active) begin
                        r_ran    <= 1'b1;
                        r_runner <= r_t;
                        r_ent    <= run_ent;
                        if (rd_ent.st == edf_pkg::RS_PREEMPT) begin
                            r_state <= S_R_EM;
                        end else begin
                            r_pos   <= '0;
                            r_state <= S_D_RD;
                        end
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_R_RD;
                    end
                end
                S_R_EM: begin
                    if (slot_free) begin
                        r_pos   <= '0;
                        r_state <= S_D_RD;
                    end
                end
                S_D_RD: begin
                    if (r_pos < n_eff) begin
                        r_t     <= r_pos[IDXW-1:0];
                        r_state <= S_D_EX;
                    end else begin
                        r_state <= S_T_EM;
                    end
                end
                S_D_EX: begin
                    r_pos   <= r_pos + PW'(1);
                    r_state <= S_D_RD;
                end
                S_T_EM: begin
                    if (slot_free) begin
                        r_time  <= r_time + 32'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_omc, r_opc, r_otime, r_orun, r_otask};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // the last beat of a tick is always the tick end record
    a_last_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == edf_pkg::EV_TICK)))
        else $error("tlast and tick end kind disagree");

    // counters only grow while a tick is in progress
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_pcnt >= $past(r_pcnt) && r_mcnt >= $past(r_mcnt)))
        else $error("event counter went backwards");

    // tick end with no runner reports task zero
    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == edf_pkg::EV_TICK && !m_axis_tdata[3])
        |-> (m_axis_tdata[2:0] == 3'd0))
        else $error("idle tick reports a task");

    // memory is written only in the load or an active tick phase
    a_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state == S_IDLE) |-> (s_axis_tvalid && !s_axis_tuser[0]))
        else $error("table write outside a load beat");

endmodule

[tb/edf_tick_scheduler_tb.sv]
// edf_tick_scheduler_tb: self-checking testbench for the EDF tick scheduler.
// Load and tick beats are fed through the slave stream. Every event record that comes
// out is checked against a cycle-free predictor of the scheduler kept in the bench.
// Depends on edf_pkg and edf_tick_scheduler.
`timescale 1ns / 1ps

module edf_tick_scheduler_tb;

    localparam int NT        = 8;      // table depth, as in the block
    localparam int DRAIN     = 2000;   // longest tick / load re-sort, with margin
    localparam int WD_LIMIT  = 20000;  // cycles with no beat on either side
    localparam int HOLD_LEN  = 400;    // long receiver stall
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 60;

    typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  id;
        logic        ap;
        logic [15:0] dl;   // deadline / release delay, or register value on ROW_CFG
        logic [15:0] ex;   // exec time, or register index on ROW_CFG
    } t_stim_row;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  task_id;
        logic        running;
        logic [31:0] at_time;
        logic [15:0] preempts;
        logic [15:0] misses;
        logic        last;
    } t_sched_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // task_id, is_aperiodic, task_deadline, exec_time
    logic [0:0]  s_axis_tuser = '0;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;       // event_task, any_running, tick_time, preempt, miss
    logic [2:0]  m_axis_tuser;       // event_kind
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    edf_tick_scheduler #(.MAX_TASKS(NT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Scheduler predictor: own copy of the table and config
    // ---------------------------------------------------------------
    logic [3:0]  cfg_task_count = edf_pkg::TASK_COUNT_RST;
    logic [15:0] cfg_aper_dl    = edf_pkg::APER_DL_RST;
    logic [2:0]  prio[NT];
    int          countdown[NT];
    logic [15:0] remaining[NT];
    logic [2:0]  rstate[NT];
    logic [15:0] period_ref[NT];
    logic [15:0] exec_ref[NT];
    logic        aper[NT];
    logic [31:0] now_ticks = '0;
    logic [15:0] preempt_cnt = '0;
    logic [15:0] miss_cnt = '0;

    t_sched_event pending_events[$];

    initial begin
        for (int i = 0; i < NT; i++) begin
            prio[i] = i[2:0];
            countdown[i] = 0;
            remaining[i] = '0;
            rstate[i] = edf_pkg::RS_UNREL;
            period_ref[i] = '0;
            exec_ref[i] = '0;
            aper[i] = 1'b0;
        end
    end

    // EDF order: earlier countdown first, then less remaining work
    function automatic bit ranks_below(logic [2:0] a, logic [2:0] b);
        if (countdown[a] != countdown[b])
            return countdown[a] > countdown[b];
        return remaining[a] > remaining[b];
    endfunction

    task automatic resort_by_deadline();
        logic [2:0] t;
        for (int i = 1; i < NT; i++)
            for (int j = i; j > 0 && ranks_below(prio[j-1], prio[j]); j--) begin
                t = prio[j-1];
                prio[j-1] = prio[j];
                prio[j] = t;
            end
    endtask

    task automatic log_event(logic [2:0] kind, logic [2:0] tid, logic run, logic [31:0] at);
        t_sched_event e;
        e.kind = kind; e.task_id = tid; e.running = run; e.at_time = at;
        e.preempts = preempt_cnt; e.misses = miss_cnt; e.last = 1'b0;
        pending_events.push_back(e);
    endtask

    task automatic apply_beat(logic act, logic [2:0] id, logic ap_in,
                              logic [15:0] dl, logic [15:0] ex);
        int           n;
        logic [31:0]  at;
        logic [2:0]   t;
        logic [2:0]   runner;
        bit           reloaded, seen, ran;
        longint       d;
        t_sched_event e;
        n = (int'(cfg_task_count) > NT) ? NT : int'(cfg_task_count);
        at = now_ticks;
        reloaded = 0; seen = 0; ran = 0; runner = '0;
        if (!act) begin
            aper[id] = ap_in;
            period_ref[id] = dl;
            exec_ref[id] = ex;
            countdown[id] = int'(dl);
            remaining[id] = ex;
            rstate[id] = edf_pkg::RS_UNREL;
            resort_by_deadline();
            return;
        end
        if (at == 32'd0)
            for (int i = 0; i < n; i++)
                if (!aper[i]) rstate[i] = edf_pkg::RS_REL;
        // completions, misses, reloads in priority order
        for (int i = 0; i < NT; i++) begin
            t = prio[i];
            if (int'(t) >= n) continue;
            if (remaining[t] == 16'd0 && rstate[t] != edf_pkg::RS_DONE) begin
                rstate[t] = edf_pkg::RS_DONE;
                log_event(edf_pkg::EV_DONE, t, 1'b0, at);
            end
            if (countdown[t] == 0) begin
                if (remaining[t] > 16'd0 && rstate[t] != edf_pkg::RS_UNREL) begin
                    rstate[t] = edf_pkg::RS_MISSED;
                    if (miss_cnt != 16'hFFFF) miss_cnt++;
                    log_event(edf_pkg::EV_MISS, t, 1'b0, at);
                end
                reloaded = 1;
                if (aper[t]) begin
                    if (rstate[t] != edf_pkg::RS_DONE) begin
                        d = longint'(cfg_aper_dl) - longint'(at);
                        if (d < -131072) d = -131072;
                        countdown[t] = int'(d);
                        rstate[t] = edf_pkg::RS_REL;
                    end else begin
                        countdown[t] = -1;   // done aperiodic stays frozen
                    end
                end else begin
                    countdown[t] = int'(period_ref[t]);
                    remaining[t] = exec_ref[t];
                    rstate[t] = edf_pkg::RS_REL;
                end
            end
        end
        if (reloaded) resort_by_deadline();
        // only the highest-priority running task keeps the CPU
        for (int i = 0; i < NT; i++) begin
            t = prio[i];
            if (int'(t) >= n || rstate[t] != edf_pkg::RS_RUN) continue;
            if (seen) begin
                if (preempt_cnt != 16'hFFFF) preempt_cnt++;
                rstate[t] = edf_pkg::RS_PREEMPT;
                log_event(edf_pkg::EV_PREEMPT, t, 1'b0, at);
            end
            seen = 1;
        end
        for (int i = 0; i < NT; i++) begin
            t = prio[i];
            if (int'(t) >= n) continue;
            if (rstate[t] >= edf_pkg::RS_REL && rstate[t] <= edf_pkg::RS_PREEMPT) begin
                if (rstate[t] == edf_pkg::RS_PREEMPT)
                    log_event(edf_pkg::EV_RESUME, t, 1'b0, at);
                rstate[t] = edf_pkg::RS_RUN;
                if (remaining[t] > 16'd0) remaining[t]--;
                runner = t;
                ran = 1;
                break;
            end
        end
        for (int i = 0; i < n; i++)
            if (countdown[i] >= 0) countdown[i]--;
        log_event(edf_pkg::EV_TICK, runner, ran, at);
        e = pending_events.pop_back();
        e.last = 1'b1;
        pending_events.push_back(e);
        now_ticks = at + 32'd1;
    endtask

    // ---------------------------------------------------------------
    // Output checker
    // ---------------------------------------------------------------
    int errors = 0;

    always @(posedge i_clk) begin
        t_sched_event exp_ev, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.task_id = m_axis_tdata[2:0];
            got.running = m_axis_tdata[3];
            got.at_time = m_axis_tdata[35:4];
            got.preempts = m_axis_tdata[51:36];
            got.misses = m_axis_tdata[67:52];
            got.last = m_axis_tlast;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event beat: kind %0d task %0d t=%0d",
                             got.kind, got.task_id, got.at_time);
            end else begin
                exp_ev = pending_events.pop_front();
                if (got != exp_ev) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp k%0d t%0d r%0d @%0d p%0d m%0d l%0d / got k%0d t%0d r%0d @%0d p%0d m%0d l%0d",
                                 exp_ev.kind, exp_ev.task_id, exp_ev.running, exp_ev.at_time,
                                 exp_ev.preempts, exp_ev.misses, exp_ev.last,
                                 got.kind, got.task_id, got.running, got.at_time,
                                 got.preempts, got.misses, got.last);
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("[edf_tick_scheduler] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random tready gaps, optional long hold-off
    // ---------------------------------------------------------------
    bit no_gaps   = 0;
    bit hold_req  = 0;

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic send_beat(logic act, logic [2:0] id, logic ap_in,
                             logic [15:0] dl, logic [15:0] ex);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, ex, dl, ap_in, id};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_beat(act, id, ap_in, dl, ex);
    endtask

    // drop valid, wait for every event, then let any load re-sort finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == edf_pkg::REG_TASK_COUNT) cfg_task_count = val[3:0];
        else cfg_aper_dl = val;
    endtask

    // directed part: every entry is loaded before the first tick so no reload
    // ever reads an entry that was never written
    t_stim_row directed[] = '{
        '{ROW_LOAD, 3'd0, 1'b0, 16'd4,     16'd2},
        '{ROW_LOAD, 3'd1, 1'b0, 16'd3,     16'd3},
        '{ROW_LOAD, 3'd2, 1'b1, 16'd2,     16'd1},
        '{ROW_LOAD, 3'd3, 1'b0, 16'd0,     16'd0},     // zero period, zero work
        '{ROW_LOAD, 3'd4, 1'b0, 16'hFFFF,  16'hFFFF},  // field maxima
        '{ROW_LOAD, 3'd5, 1'b1, 16'd0,     16'd5},     // aperiodic, released at once
        '{ROW_LOAD, 3'd6, 1'b0, 16'd2,     16'd5},     // cannot make its deadline
        '{ROW_LOAD, 3'd7, 1'b1, 16'hFFFF,  16'hFFFF},
        '{ROW_CFG,  3'd0, 1'b0, 16'd8,     16'(edf_pkg::REG_TASK_COUNT)},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},     // time zero: periodic release
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_CFG,  3'd0, 1'b0, 16'd0,     16'(edf_pkg::REG_TASK_COUNT)},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},     // empty table: tick end only
        '{ROW_CFG,  3'd0, 1'b0, 16'd15,    16'(edf_pkg::REG_TASK_COUNT)},  // clamps to 8
        '{ROW_CFG,  3'd0, 1'b0, 16'd0,     16'(edf_pkg::REG_APER_DL)},  // deadline past
        '{ROW_LOAD, 3'd2, 1'b1, 16'd1,     16'd2},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0},
        '{ROW_CFG,  3'd0, 1'b0, 16'hFFFF,  16'(edf_pkg::REG_APER_DL)},
        '{ROW_LOAD, 3'd5, 1'b1, 16'd0,     16'd1},
        '{ROW_TICK, 3'd0, 1'b0, 16'd0,     16'd0}
    };

    initial begin
        logic [15:0] dl, ex, tc;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            case (directed[r].kind)
                ROW_CFG:  write_reg(directed[r].ex[0], directed[r].dl);
                ROW_LOAD: send_beat(1'b0, directed[r].id, directed[r].ap,
                                    directed[r].dl, directed[r].ex);
                default:  send_beat(1'b1, 3'd0, 1'b0, 16'd0, 16'd0);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       tc = 16'd0;
                1:       tc = 16'd15;
                2:       tc = 16'd8;
                default: tc = 16'($urandom_range(1, 8));
            endcase
            write_reg(edf_pkg::REG_TASK_COUNT, tc);
            case ($urandom_range(0, 3))
                0:       write_reg(edf_pkg::REG_APER_DL, 16'd0);
                1:       write_reg(edf_pkg::REG_APER_DL, 16'hFFFF);
                2:       write_reg(edf_pkg::REG_APER_DL, 16'($urandom_range(0, 16'hFFFF)));
                default: write_reg(edf_pkg::REG_APER_DL,
                                   now_ticks[15:0] + 16'($urandom_range(5, 60)));
            endcase
            no_gaps = (ph == 1);
            if (ph == 3) hold_req = 1;   // block backs up while loads and ticks keep coming
            for (int k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    dl = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 12));
                    ex = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 6));
                    send_beat(1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              dl, ex);
                end else begin
                    // tick beats still carry random payload bits, which the block ignores
                    send_beat(1'b1, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              16'($urandom), 16'($urandom));
                end
            end
            no_gaps = 0;
        end

        drain();
        if (errors == 0)
            $display("[edf_tick_scheduler] OK");
        else
            $display("[edf_tick_scheduler] ERROR");
        $finish;
    end

endmodule
